/* rtl/tree_lca_binary_lifting_macros.svh */
// ---------------------------------------------------------------------------
// tree_lca_binary_lifting assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef TREE_LCA_BINARY_LIFTING_MACROS_SVH
`define TREE_LCA_BINARY_LIFTING_MACROS_SVH

// same-cycle implication
`define TLCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tlca_pkg.sv */
// ---------------------------------------------------------------------------
// tlca_pkg
// shared sizes, types and helpers of the binary lifting lca engine
// ---------------------------------------------------------------------------
package tlca_pkg;

  // table sizes
  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 10;

  // field widths
  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int ADDR_W  = $clog2(MAX_NODES);
  localparam int LVL_W   = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int SUM_W   = ((DEPTH_W > LIFT_LEVELS) ? DEPTH_W : LIFT_LEVELS) + 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  // ancestor row of one node
  typedef logic [LIFT_LEVELS-1:0][NODE_W-1:0] anc_t;

  // one memory word: node depth plus its ancestor row
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    anc_t               anc;
  } row_t;

  // memory request from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    row_t              wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  // input item
  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } item_t;

  // result item
  typedef struct packed {
    logic [NODE_W-1:0]  answer_node;
    logic [DEPTH_W-1:0] answer_depth;
  } res_t;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // node number to table address, out of range maps to the sentinel
  function automatic logic [ADDR_W-1:0] to_addr(input logic [NODE_W-1:0] n);
    logic [ADDR_W-1:0] a;
    a = '0;
    if (32'(n) < MAX_NODES) a = ADDR_W'(n);
    return a;
  endfunction

  // table address back to a node number
  function automatic logic [NODE_W-1:0] to_node(input logic [ADDR_W-1:0] a);
    return NODE_W'(a);
  endfunction

endpackage

/* rtl/tlca_row_mem.sv */
// ---------------------------------------------------------------------------
// tlca_row_mem
// node row memory: one write port, two read ports, registered read data
// ---------------------------------------------------------------------------
module tlca_row_mem
  import tlca_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output row_t     rd_a,
  output row_t     rd_b
);

  row_t mem [MAX_NODES];
  row_t rd_a_r;
  row_t rd_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
  end

  // read ports
  always_ff @(posedge clk) begin
    rd_a_r <= mem[req.raddr_a];
    rd_b_r <= mem[req.raddr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

/* rtl/tlca_engine.sv */
// ---------------------------------------------------------------------------
// tlca_engine
// sequencer: clearing pass, row build on load, two lifting passes on query
// ---------------------------------------------------------------------------
`include "tree_lca_binary_lifting_macros.svh"

module tlca_engine
  import tlca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  item_t    in_item,
  output logic     res_valid,
  input  logic     res_ready,
  output res_t     res,
  output mem_req_t mem_req,
  input  row_t     rd_a,
  input  row_t     rd_b
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RD0     = 4'd2;
  localparam logic [3:0] S_LD_STEP = 4'd3;
  localparam logic [3:0] S_LD_WR   = 4'd4;
  localparam logic [3:0] S_P1      = 4'd5;
  localparam logic [3:0] S_P1_CAP  = 4'd6;
  localparam logic [3:0] S_CHK     = 4'd7;
  localparam logic [3:0] S_P2      = 4'd8;
  localparam logic [3:0] S_P2_CAP  = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;
  localparam logic [3:0] S_FIN_CAP = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  localparam logic [LVL_W-1:0]  LVL_TOP  = LVL_W'(LIFT_LEVELS - 1);
  localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(MAX_NODES - 1);

  logic [3:0]         state_r,     state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r,   clr_cnt_nxt;
  logic [LVL_W-1:0]   lvl_r,       lvl_nxt;
  logic               cmd_r,       cmd_nxt;
  logic [ADDR_W-1:0]  a_r,         a_nxt;
  logic [ADDR_W-1:0]  b_r,         b_nxt;
  logic [ADDR_W-1:0]  x_r,         x_nxt;
  logic [ADDR_W-1:0]  y_r,         y_nxt;
  row_t               row_x_r,     row_x_nxt;
  row_t               row_y_r,     row_y_nxt;
  anc_t               new_anc_r,   new_anc_nxt;
  logic [DEPTH_W-1:0] new_depth_r, new_depth_nxt;
  logic [DEPTH_W-1:0] depth_b_r,   depth_b_nxt;
  res_t               res_r,       res_nxt;

  logic [LVL_W-1:0]  lvl_prev;
  logic [NODE_W-1:0] prev_node;
  logic [NODE_W-1:0] entry_node;
  logic [SUM_W-1:0]  lift_need;
  logic              lift_ok;
  logic [NODE_W-1:0] anc_x;
  logic [NODE_W-1:0] anc_y;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // row build: entry at lvl is entry lvl-1 of the row just read,
  // forwarded from the row under construction when it is the node itself
  assign lvl_prev   = lvl_r - LVL_W'(1);
  assign prev_node  = new_anc_r[lvl_prev];
  assign entry_node = (to_addr(prev_node) == a_r) ? prev_node : rd_a.anc[lvl_prev];

  // first pass lift test
  assign lift_need = SUM_W'(row_y_r.depth) + (SUM_W'(1) << lvl_r);
  assign lift_ok   = (SUM_W'(row_x_r.depth) >= lift_need);

  // second pass ancestors at the current level
  assign anc_x = row_x_r.anc[lvl_r];
  assign anc_y = row_y_r.anc[lvl_r];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    lvl_nxt       = lvl_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    row_x_nxt     = row_x_r;
    row_y_nxt     = row_y_r;
    new_anc_nxt   = new_anc_r;
    new_depth_nxt = new_depth_r;
    depth_b_nxt   = depth_b_r;
    res_nxt       = res_r;
    mem_req       = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt_r;
        clr_cnt_nxt   = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_TOP) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        mem_req.raddr_a = to_addr(in_item.node_a);
        mem_req.raddr_b = to_addr(in_item.node_b);
        if (in_valid) begin
          cmd_nxt   = in_item.cmd;
          a_nxt     = to_addr(in_item.node_a);
          b_nxt     = to_addr(in_item.node_b);
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        if (cmd_r == CMD_LOAD) begin
          depth_b_nxt = rd_b.depth;
          if (a_r == '0) begin
            // sentinel load changes nothing
            res_nxt.answer_node  = to_node(b_r);
            res_nxt.answer_depth = rd_b.depth;
            state_nxt            = S_DONE;
          end else begin
            new_anc_nxt[0] = to_node(b_r);
            new_depth_nxt  = (rd_b.depth == DEPTH_MAX) ? DEPTH_MAX
                                                       : rd_b.depth + DEPTH_W'(1);
            mem_req.raddr_a = b_r;
            lvl_nxt         = LVL_W'(1);
            state_nxt       = (LIFT_LEVELS == 1) ? S_LD_WR : S_LD_STEP;
          end
        end else begin
          // deeper node goes to x
          if (rd_a.depth < rd_b.depth) begin
            x_nxt     = b_r;
            row_x_nxt = rd_b;
            y_nxt     = a_r;
            row_y_nxt = rd_a;
          end else begin
            x_nxt     = a_r;
            row_x_nxt = rd_a;
            y_nxt     = b_r;
            row_y_nxt = rd_b;
          end
          lvl_nxt   = LVL_TOP;
          state_nxt = S_P1;
        end
      end
      S_LD_STEP: begin
        new_anc_nxt[lvl_r] = entry_node;
        mem_req.raddr_a    = to_addr(entry_node);
        if (lvl_r == LVL_TOP) begin
          state_nxt = S_LD_WR;
        end else begin
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      S_LD_WR: begin
        mem_req.we          = 1'b1;
        mem_req.waddr       = a_r;
        mem_req.wdata.depth = new_depth_r;
        mem_req.wdata.anc   = new_anc_r;
        res_nxt.answer_node  = to_node(b_r);
        res_nxt.answer_depth = (b_r == a_r) ? new_depth_r : depth_b_r;
        state_nxt            = S_DONE;
      end
      S_P1: begin
        if (lift_ok) begin
          mem_req.raddr_a = to_addr(row_x_r.anc[lvl_r]);
          x_nxt           = to_addr(row_x_r.anc[lvl_r]);
          state_nxt       = S_P1_CAP;
        end else if (lvl_r == '0) begin
          state_nxt = S_CHK;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      S_P1_CAP: begin
        row_x_nxt = rd_a;
        if (lvl_r == '0) begin
          state_nxt = S_CHK;
        end else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = S_P1;
        end
      end
      S_CHK: begin
        if (x_r == y_r) begin
          res_nxt.answer_node  = to_node(x_r);
          res_nxt.answer_depth = row_x_r.depth;
          state_nxt            = S_DONE;
        end else begin
          lvl_nxt   = LVL_TOP;
          state_nxt = S_P2;
        end
      end
      S_P2: begin
        if (anc_x != anc_y) begin
          mem_req.raddr_a = to_addr(anc_x);
          mem_req.raddr_b = to_addr(anc_y);
          x_nxt           = to_addr(anc_x);
          y_nxt           = to_addr(anc_y);
          state_nxt       = S_P2_CAP;
        end else if (lvl_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      S_P2_CAP: begin
        row_x_nxt = rd_a;
        row_y_nxt = rd_b;
        if (lvl_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = S_P2;
        end
      end
      S_FIN: begin
        // parent of x is the answer, its depth needs one more read
        mem_req.raddr_a     = to_addr(row_x_r.anc[0]);
        res_nxt.answer_node = row_x_r.anc[0];
        state_nxt           = S_FIN_CAP;
      end
      S_FIN_CAP: begin
        res_nxt.answer_depth = rd_a.depth;
        state_nxt            = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      lvl_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      lvl_r     <= lvl_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    row_x_r     <= row_x_nxt;
    row_y_r     <= row_y_nxt;
    new_anc_r   <= new_anc_nxt;
    new_depth_r <= new_depth_nxt;
    depth_b_r   <= depth_b_nxt;
    res_r       <= res_nxt;
  end

  // checks
  `TLCA_ASSERT_NOW(a_sentinel_kept, mem_req.we && (state_r != S_CLEAR), mem_req.waddr != '0, "sentinel row written by a load")
  `TLCA_ASSERT_NOW(a_build_lvl, state_r == S_LD_STEP, (lvl_r != '0) && (32'(lvl_r) < LIFT_LEVELS), "row build level out of range")
  `TLCA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_r), "result dropped while stalled")
  `TLCA_ASSERT_NEXT(a_no_early_res, in_valid && in_ready, !res_valid, "result in the cycle after accept")

endmodule

/* rtl/tree_lca_binary_lifting.sv */
// ---------------------------------------------------------------------------
// tree_lca_binary_lifting
// lowest common ancestor engine over a binary lifting table in one memory
// ---------------------------------------------------------------------------
//  channel | direction | ports                         | contents
//  in_     | input     | tvalid tready tdata tuser     | load or query item
//  out_    | output    | tvalid tready tdata           | ancestor and depth
//
//  a load reads one row per doubling level, then writes one row; a load of the
//  sentinel writes nothing. in a query the first pass visits every level, and
//  each lift in either pass is a dependent row read plus a capture.
//  after reset a clearing pass writes every row to zero, with in_tready low.
//  the result sits in an output register; a stalled out_tready holds the
//  engine only once that register is full.
// ---------------------------------------------------------------------------
module tree_lca_binary_lifting
  import tlca_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // node_a [9:0], node_b [19:10], zero fill above
  input  logic [((2*NODE_W+7)/8)*8-1:0] in_tdata,
  // cmd [0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // answer_node [9:0], answer_depth [19:10], zero fill above
  output logic [((NODE_W+DEPTH_W+7)/8)*8-1:0] out_tdata
);

  localparam int OUT_DATA_W = ((NODE_W + DEPTH_W + 7) / 8) * 8;

  item_t    in_item;
  res_t     res;
  logic     res_valid;
  logic     res_ready;
  mem_req_t mem_req;
  row_t     rd_a;
  row_t     rd_b;

  logic     out_valid_r, out_valid_nxt;
  res_t     out_res_r,   out_res_nxt;

  // unpack input item
  assign in_item.cmd    = in_tuser;
  assign in_item.node_a = in_tdata[NODE_W-1:0];
  assign in_item.node_b = in_tdata[2*NODE_W-1:NODE_W];

  tlca_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  tlca_row_mem u_row_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_res_r.answer_depth, out_res_r.answer_node});

endmodule

/* verif/tree_lca_binary_lifting_tb.sv */
// ---------------------------------------------------------------------------
// tree_lca_binary_lifting_tb
// drives load and query items into the lca engine and checks every answer
// against an in-bench binary lifting predictor or a typed row's fixed answer.
// a short directed table covers the sentinel, unloaded parents, reloads and the
// field extremes; a deep chain over every node number then reaches all lift
// levels and depth saturation; random preorder trees with noise items follow.
// ---------------------------------------------------------------------------
module tree_lca_binary_lifting_tb;
  import tlca_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W        = ((2*NODE_W+7)/8)*8;
  localparam int OUT_W       = ((NODE_W+DEPTH_W+7)/8)*8;
  localparam int ITEMS_TOTAL = 1950;
  localparam int WATCH_LIMIT = 5000;
  localparam int IDLE_PCT    = 18;
  localparam int DIR_N       = 21;

  // one directed row, want is used only when typed is set
  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic              typed;
    res_t              want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{CMD_QUERY, 10'd0,    10'd0,    1'b1, '{10'd0,   10'd0}},
    '{CMD_QUERY, 10'd1023, 10'd1,    1'b1, '{10'd0,   10'd0}},
    '{CMD_LOAD,  10'd0,    10'd5,    1'b1, '{10'd5,   10'd0}},
    '{CMD_LOAD,  10'd1,    10'd0,    1'b1, '{10'd0,   10'd0}},
    '{CMD_LOAD,  10'd2,    10'd1,    1'b1, '{10'd1,   10'd1}},
    '{CMD_LOAD,  10'd1023, 10'd2,    1'b1, '{10'd2,   10'd2}},
    '{CMD_LOAD,  10'd3,    10'd1,    1'b1, '{10'd1,   10'd1}},
    '{CMD_QUERY, 10'd1023, 10'd3,    1'b1, '{10'd1,   10'd1}},
    '{CMD_QUERY, 10'd1023, 10'd1023, 1'b1, '{10'd1023, 10'd3}},
    '{CMD_QUERY, 10'd2,    10'd1023, 1'b1, '{10'd2,   10'd2}},
    '{CMD_QUERY, 10'd1023, 10'd2,    1'b1, '{10'd2,   10'd2}},
    '{CMD_LOAD,  10'd0,    10'd3,    1'b1, '{10'd3,   10'd2}},
    '{CMD_QUERY, 10'd0,    10'd1023, 1'b1, '{10'd0,   10'd0}},
    '{CMD_LOAD,  10'd5,    10'd900,  1'b1, '{10'd900, 10'd0}},
    '{CMD_QUERY, 10'd5,    10'd1023, 1'b0, '{10'd0,   10'd0}},
    '{CMD_LOAD,  10'd512,  10'd3,    1'b1, '{10'd3,   10'd2}},
    '{CMD_QUERY, 10'd512,  10'd1023, 1'b1, '{10'd1,   10'd1}},
    '{CMD_LOAD,  10'd341,  10'd682,  1'b1, '{10'd682, 10'd0}},
    '{CMD_QUERY, 10'd341,  10'd682,  1'b0, '{10'd0,   10'd0}},
    '{CMD_LOAD,  10'd2,    10'd3,    1'b1, '{10'd3,   10'd2}},
    '{CMD_QUERY, 10'd1023, 10'd2,    1'b0, '{10'd0,   10'd0}}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // predictor state
  logic [DEPTH_W-1:0] depth_of [MAX_NODES];
  logic [NODE_W-1:0]  lift_tab [MAX_NODES][LIFT_LEVELS];

  res_t answer_q [$];
  int   bad_answers;
  int   items_sent;
  int   quiet_cycles;
  bit   calm;

  tree_lca_binary_lifting dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // binary lifting predictor, updates the tables on a load
  function automatic res_t lca_predict(input item_t it);
    logic [NODE_W-1:0] a, b, x, y, t;
    int                d;
    res_t              r;
    a = (int'(it.node_a) < MAX_NODES) ? it.node_a : '0;
    b = (int'(it.node_b) < MAX_NODES) ? it.node_b : '0;
    if (it.cmd == CMD_LOAD) begin
      if (a != 0) begin
        d = int'(depth_of[b]) + 1;
        if (d > int'(DEPTH_MAX)) d = int'(DEPTH_MAX);
        depth_of[a] = DEPTH_W'(d);
        lift_tab[a][0] = b;
        for (int lvl = 1; lvl < LIFT_LEVELS; lvl++)
          lift_tab[a][lvl] = lift_tab[lift_tab[a][lvl-1]][lvl-1];
      end
      x = b;
    end else begin
      x = a;
      y = b;
      if (depth_of[x] < depth_of[y]) begin
        t = x;
        x = y;
        y = t;
      end
      // bring the deeper node up to the other's depth
      for (int lvl = LIFT_LEVELS-1; lvl >= 0; lvl--)
        if (int'(depth_of[x]) >= int'(depth_of[y]) + (1 << lvl)) x = lift_tab[x][lvl];
      // lift both while their ancestors differ
      if (x != y) begin
        for (int lvl = LIFT_LEVELS-1; lvl >= 0; lvl--) begin
          if (lift_tab[x][lvl] != lift_tab[y][lvl]) begin
            x = lift_tab[x][lvl];
            y = lift_tab[y][lvl];
          end
        end
        x = lift_tab[x][0];
      end
    end
    r.answer_node  = x;
    r.answer_depth = depth_of[x];
    return r;
  endfunction

  // push one item through the input channel, then idle at random
  task automatic send_item(input logic c, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic typed,
                           input res_t want);
    item_t it;
    res_t  r;
    it.cmd    = c;
    it.node_a = a;
    it.node_b = b;
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= IN_W'({b, a});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = lca_predict(it);
    answer_q = {answer_q, (typed ? want : r)};
    items_sent++;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // result side: check each accepted answer, then pick the next tready
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          bad_answers++;
          if (bad_answers <= 10)
            $display("unexpected answer: node %0d depth %0d",
                     out_tdata[NODE_W-1:0], out_tdata[NODE_W+DEPTH_W-1:NODE_W]);
        end else begin
          res_t want;
          want = answer_q.pop_front();
          if (want.answer_node !== out_tdata[NODE_W-1:0] ||
              want.answer_depth !== out_tdata[NODE_W+DEPTH_W-1:NODE_W]) begin
            bad_answers++;
            if (bad_answers <= 10)
              $display("answer mismatch: expected node %0d depth %0d, got node %0d depth %0d",
                       want.answer_node, want.answer_depth, out_tdata[NODE_W-1:0],
                       out_tdata[NODE_W+DEPTH_W-1:NODE_W]);
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("tree_lca_binary_lifting_tb: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [NODE_W-1:0] chain [MAX_NODES-1];
    logic [NODE_W-1:0] round_nodes [$];
    logic [NODE_W-1:0] t, node, par;
    int                j, n;

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_LOAD;
    rst_n       = 1'b0;
    calm        = 1'b0;
    bad_answers = 0;
    items_sent  = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      depth_of[i] = '0;
      for (int lvl = 0; lvl < LIFT_LEVELS; lvl++) lift_tab[i][lvl] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_N; i++)
      send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].typed,
                DIR_ROWS[i].want);

    // deep chain over a shuffled order of every nonzero node
    for (int i = 0; i < MAX_NODES-1; i++) chain[i] = NODE_W'(i + 1);
    for (int i = MAX_NODES-2; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = chain[i];
      chain[i] = chain[j];
      chain[j] = t;
    end
    for (int i = 0; i < MAX_NODES-1; i++) begin
      calm = (i >= 400 && i < 700);
      send_item(CMD_LOAD, chain[i], (i == 0) ? '0 : chain[i-1], 1'b0, '0);
      if ($urandom_range(7) == 0)
        send_item(CMD_QUERY, chain[$urandom_range(i)], chain[$urandom_range(i)], 1'b0, '0);
    end
    calm = 1'b0;
    // parent at the deepest depth saturates the child
    send_item(CMD_LOAD, chain[0], chain[MAX_NODES-2], 1'b0, '0);
    repeat (12)
      send_item(CMD_QUERY, chain[$urandom_range(MAX_NODES-2)],
                chain[$urandom_range(MAX_NODES-2)], 1'b0, '0);

    // random preorder trees with queries and noise items
    while (items_sent < ITEMS_TOTAL) begin
      round_nodes.delete();
      n = $urandom_range(2, 40);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99) < 15)
          send_item(logic'($urandom_range(1)), NODE_W'($urandom_range(MAX_NODES-1)),
                    NODE_W'($urandom_range(MAX_NODES-1)), 1'b0, '0);
        node = NODE_W'($urandom_range(1, MAX_NODES-1));
        par  = (round_nodes.size() == 0 || $urandom_range(15) == 0) ? '0 :
               round_nodes[$urandom_range(round_nodes.size()-1)];
        send_item(CMD_LOAD, node, par, 1'b0, '0);
        round_nodes = {round_nodes, node};
        if ($urandom_range(2) == 0)
          send_item(CMD_QUERY, round_nodes[$urandom_range(round_nodes.size()-1)],
                    round_nodes[$urandom_range(round_nodes.size()-1)], 1'b0, '0);
      end
      repeat ($urandom_range(1, 6))
        send_item(CMD_QUERY, round_nodes[$urandom_range(round_nodes.size()-1)],
                  round_nodes[$urandom_range(round_nodes.size()-1)], 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // drain, then allow for a late extra answer
    while (answer_q.size() != 0) @(posedge clk);
    repeat (4*LIFT_LEVELS + 16) @(posedge clk);
    if (bad_answers == 0) begin
      $display("tree_lca_binary_lifting_tb: done, clean");
    end else begin
      $display("tree_lca_binary_lifting_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tlca_pkg.sv
rtl/tlca_row_mem.sv
rtl/tlca_engine.sv
rtl/tree_lca_binary_lifting.sv
verif/tree_lca_binary_lifting_tb.sv
